// ----- hw/rtl/bounded_rational_price_scaler_core_macros.svh -----
// Assertion macros for the price scaler.
`ifndef BOUNDED_RATIONAL_PRICE_SCALER_CORE_MACROS_SVH
`define BOUNDED_RATIONAL_PRICE_SCALER_CORE_MACROS_SVH
`ifndef SYNTH
`define BRPS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define BRPS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/brps_pkg.sv -----
`default_nettype none
package brps_pkg;
  localparam int AMOUNT_BITS = 63;
  localparam int RATIO_BITS = 16;
  localparam int WIDE_BITS = 80;
  localparam logic [62:0] SUPPLY_RESET = 63'd1000000000000000;
  localparam logic [15:0] RDEN_RESET = 16'd1000;
  localparam logic CFG_SUPPLY = 1'b0;
  localparam logic CFG_RDEN = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_MUL   = 11'b00000000010,
    ST_RED   = 11'b00000000100,
    ST_GCD   = 11'b00000001000,
    ST_DIVN  = 11'b00000010000,
    ST_DIVD  = 11'b00000100000,
    ST_CHK   = 11'b00001000000,
    ST_HALF  = 11'b00010000000,
    ST_CMP   = 11'b00100000000,
    ST_CLAMP = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/brps_if.sv -----
`default_nettype none
interface brps_stream_if #(
  parameter int W = 1
) (
  input wire clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bounded_rational_price_scaler_core.sv -----
// The time per item is data dependent, set by the serial multiply, the binary gcd and the
// bit-serial divides per halving pass.
// Throughput: one item at a time; the next item is taken after the result is accepted.
// Reset: rst_n is synchronous, active low; the supply and ratio-denominator registers return to 1e15 and 1000.
`default_nettype none
`include "bounded_rational_price_scaler_core_macros.svh"
module bounded_rational_price_scaler_core #(
  parameter int AMOUNT_BITS = brps_pkg::AMOUNT_BITS,
  parameter int RATIO_BITS = brps_pkg::RATIO_BITS
) (
  input wire clk,
  input wire rst_n,
  brps_stream_if.sink   in_ch,
  brps_stream_if.source out_ch,
  brps_stream_if.sink   cfg_ch
);
  localparam int W = brps_pkg::WIDE_BITS;
  localparam int MCW = $clog2(RATIO_BITS + 1);

  logic [62:0] supply_r;
  logic [15:0] rden_r;
  brps_pkg::state_t st_r, st_nxt;
  logic kind_r, status_r;
  logic [W-1:0] n_r, d_r, pn_r, pd_r, acc_n_r, acc_d_r, g_r, lim;
  logic [RATIO_BITS-1:0] mn_r, md_r;
  logic [MCW-1:0] mc_r;
  logic [62:0] ob_r, oq_r;
  logic [W-1:0] div_num, div_den, hn, hd;
  brps_pkg::unit_ctl_t gctl, dctl;
  logic gdone, ddone;
  logic [W-1:0] gval, dval;

  logic in_fire, out_fire;
  logic [62:0] a_in, b_in;
  logic [15:0] r_in;
  logic k_in;
  logic [RATIO_BITS-1:0] r_m, rden_m;

  assign k_in = in_ch.data[0];
  assign a_in = in_ch.data[63:1];
  assign b_in = in_ch.data[126:64];
  assign r_in = in_ch.data[142:127];
  assign r_m = r_in[RATIO_BITS-1:0];
  assign rden_m = rden_r[RATIO_BITS-1:0];
  assign in_ch.ready = st_r == brps_pkg::ST_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = st_r == brps_pkg::ST_OUT;
  assign out_ch.data = {status_r, oq_r, ob_r};
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign lim = W'(supply_r);
  assign hn = kind_r ? (n_r >> 1) + W'(n_r[0]) : (n_r >> 1) + W'(1);
  assign hd = kind_r ? (d_r >> 1) + W'(d_r[0]) : (d_r >> 1) + W'(1);
  assign div_num = (st_r == brps_pkg::ST_DIVN) ? d_r : n_r;
  assign div_den = (st_r == brps_pkg::ST_GCD) ? gval : g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= brps_pkg::SUPPLY_RESET;
      rden_r <= brps_pkg::RDEN_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data[63] == brps_pkg::CFG_SUPPLY) supply_r <= cfg_ch.data[62:0];
      else rden_r <= {{(16 - RATIO_BITS){1'b0}}, cfg_ch.data[RATIO_BITS-1:0]};
    end
  end

  brps_gcd #(.W(W)) u_gcd (
    .clk(clk), .rst_n(rst_n), .ctl_i(gctl), .a_i(n_r), .b_i(d_r),
    .done_o(gdone), .g_o(gval)
  );
  brps_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl_i(dctl), .num_i(div_num), .den_i(div_den),
    .done_o(ddone), .q_o(dval)
  );

  always_comb begin
    st_nxt = st_r;
    gctl = '0;
    dctl = '0;
    case (st_r)
      brps_pkg::ST_IDLE: if (in_fire) begin
        if (b_in[AMOUNT_BITS-1:0] == '0 || (k_in ? r_m == '0 : rden_m == '0))
          st_nxt = brps_pkg::ST_OUT;
        else st_nxt = brps_pkg::ST_MUL;
      end
      brps_pkg::ST_MUL: if (mc_r == '0) st_nxt = brps_pkg::ST_RED;
      brps_pkg::ST_RED: begin
        if (n_r != '0) begin
          gctl.start = 1'b1;
          st_nxt = brps_pkg::ST_GCD;
        end else st_nxt = brps_pkg::ST_CHK;
      end
      brps_pkg::ST_GCD: begin
        gctl.busy = 1'b1;
        if (gdone) st_nxt = brps_pkg::ST_DIVN;
      end
      brps_pkg::ST_DIVN: begin
        dctl.busy = 1'b1;
        if (ddone) st_nxt = brps_pkg::ST_DIVD;
      end
      brps_pkg::ST_DIVD: begin
        dctl.busy = 1'b1;
        if (ddone) st_nxt = brps_pkg::ST_CHK;
      end
      brps_pkg::ST_CHK: begin
        if (pn_r != '0 && n_r == pn_r && d_r == pd_r) st_nxt = brps_pkg::ST_CLAMP;
        else if (n_r > lim || d_r > lim) st_nxt = brps_pkg::ST_HALF;
        else st_nxt = brps_pkg::ST_CMP;
      end
      brps_pkg::ST_HALF: st_nxt = brps_pkg::ST_RED;
      brps_pkg::ST_CMP: st_nxt = brps_pkg::ST_OUT;
      brps_pkg::ST_CLAMP: st_nxt = brps_pkg::ST_OUT;
      brps_pkg::ST_OUT: if (out_fire) st_nxt = brps_pkg::ST_IDLE;
      default: st_nxt = brps_pkg::ST_IDLE;
    endcase
    if (st_r == brps_pkg::ST_GCD && gdone) dctl.start = 1'b1;
    if (st_r == brps_pkg::ST_DIVN && ddone) dctl.start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= brps_pkg::ST_IDLE;
    else st_r <= st_nxt;
    case (st_r)
      brps_pkg::ST_IDLE: if (in_fire) begin
        kind_r <= k_in;
        status_r <= 1'b1;
        ob_r <= '0;
        oq_r <= '0;
        acc_n_r <= '0;
        acc_d_r <= '0;
        pn_r <= '0;
        pd_r <= '0;
        mc_r <= MCW'(RATIO_BITS);
        n_r <= W'(a_in[AMOUNT_BITS-1:0]);
        d_r <= W'(b_in[AMOUNT_BITS-1:0]);
        mn_r <= k_in ? rden_m : r_m;
        md_r <= k_in ? r_m : rden_m;
      end
      brps_pkg::ST_MUL: begin
        if (mc_r != '0) begin
          acc_n_r <= (acc_n_r << 1) + (mn_r[RATIO_BITS-1] ? n_r : '0);
          acc_d_r <= (acc_d_r << 1) + (md_r[RATIO_BITS-1] ? d_r : '0);
          mn_r <= mn_r << 1;
          md_r <= md_r << 1;
          mc_r <= mc_r - MCW'(1);
        end else begin
          n_r <= acc_n_r;
          d_r <= acc_d_r;
        end
      end
      brps_pkg::ST_RED: if (n_r == '0) d_r <= W'(1);
      brps_pkg::ST_GCD: if (gdone) g_r <= gval;
      brps_pkg::ST_DIVN: if (ddone) n_r <= dval;
      brps_pkg::ST_DIVD: if (ddone) d_r <= dval;
      brps_pkg::ST_CHK: if (n_r > lim || d_r > lim) begin
        pn_r <= n_r;
        pd_r <= d_r;
      end
      brps_pkg::ST_HALF: begin
        n_r <= hn;
        d_r <= hd;
      end
      brps_pkg::ST_CMP, brps_pkg::ST_CLAMP: begin
        status_r <= 1'b0;
        if (kind_r) begin
          ob_r <= ((n_r > lim) ? supply_r : n_r[62:0]) & {{(63 - AMOUNT_BITS){1'b0}}, {AMOUNT_BITS{1'b1}}};
          oq_r <= ((d_r > lim) ? supply_r : d_r[62:0]) & {{(63 - AMOUNT_BITS){1'b0}}, {AMOUNT_BITS{1'b1}}};
        end else begin
          ob_r <= ((d_r > lim) ? supply_r : d_r[62:0]) & {{(63 - AMOUNT_BITS){1'b0}}, {AMOUNT_BITS{1'b1}}};
          oq_r <= ((n_r > lim) ? supply_r : n_r[62:0]) & {{(63 - AMOUNT_BITS){1'b0}}, {AMOUNT_BITS{1'b1}}};
        end
      end
      default: ;
    endcase
    if (st_r == brps_pkg::ST_CHK && pn_r != '0 && n_r == pn_r && d_r == pd_r) begin
      n_r <= (n_r > lim) ? lim : n_r;
      d_r <= (d_r > lim) ? lim : d_r;
    end
  end

  `BRPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
  `BRPS_ASSERT_IMPL(a_no_overlap, clk, rst_n, !(in_ch.ready && out_ch.valid), "input taken while result pending")
  `BRPS_ASSERT_NEXT(a_err_fast, clk, rst_n, in_fire && b_in == '0, out_ch.valid && out_ch.data[126], "zero divisor not flagged")
endmodule
`default_nettype wire

// ----- hw/rtl/brps_gcd.sv -----
`default_nettype none
module brps_gcd #(
  parameter int W = brps_pkg::WIDE_BITS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  brps_pkg::unit_ctl_t ctl_i,
  input  wire [W-1:0]         a_i,
  input  wire [W-1:0]         b_i,
  output logic                done_o,
  output logic [W-1:0]        g_o
);
  // Binary gcd by shifts and subtracts; a start restarts it on new operands.
  localparam int SW = $clog2(W + 1);
  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [SW-1:0] sh_r, sh_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic          run_r, run_nxt;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    sh_nxt = sh_r;
    ph_nxt = ph_r;
    run_nxt = run_r;
    done_o = 1'b0;
    g_o = a_r;
    if (ctl_i.start) begin
      a_nxt = a_i;
      b_nxt = b_i;
      sh_nxt = '0;
      ph_nxt = 2'd0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      case (ph_r)
        2'd0: begin
          if (a_r == '0) begin
            a_nxt = b_r;
            ph_nxt = 2'd3;
          end else if (b_r == '0) begin
            ph_nxt = 2'd3;
          end else if (!a_r[0] && !b_r[0]) begin
            a_nxt = a_r >> 1;
            b_nxt = b_r >> 1;
            sh_nxt = sh_r + SW'(1);
          end else begin
            ph_nxt = 2'd1;
          end
        end
        2'd1: begin
          if (!a_r[0]) a_nxt = a_r >> 1;
          else ph_nxt = 2'd2;
        end
        2'd2: begin
          if (b_r == '0) begin
            ph_nxt = 2'd3;
          end else if (!b_r[0]) begin
            b_nxt = b_r >> 1;
          end else if (a_r > b_r) begin
            a_nxt = b_r;
            b_nxt = a_r - b_r;
          end else begin
            b_nxt = b_r - a_r;
          end
        end
        default: begin
          if (sh_r != '0) begin
            a_nxt = a_r << 1;
            sh_nxt = sh_r - SW'(1);
          end else begin
            done_o = 1'b1;
            run_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      ph_r <= 2'd0;
    end else begin
      run_r <= run_nxt;
      ph_r <= ph_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    sh_r <= sh_nxt;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/brps_div.sv -----
`default_nettype none
module brps_div #(
  parameter int W = brps_pkg::WIDE_BITS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  brps_pkg::unit_ctl_t ctl_i,
  input  wire [W-1:0]         num_i,
  input  wire [W-1:0]         den_i,
  output logic                done_o,
  output logic [W-1:0]        q_o
);
  // Restoring division, one quotient bit per cycle.
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q_r, q_nxt, den_r, den_nxt;
  logic [W:0]    rem_r, rem_nxt, trial;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;

  assign q_o = q_r;

  always_comb begin
    q_nxt = q_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_o = run_r && (cnt_r == '0);
    trial = {rem_r[W-1:0], q_r[W-1]};
    if (ctl_i.start) begin
      q_nxt = num_i;
      den_nxt = den_i;
      rem_nxt = '0;
      cnt_nxt = CW'(W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = trial - {1'b0, den_r};
          q_nxt = {q_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt = {q_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) run_r <= 1'b0;
    else run_r <= run_nxt;
    q_r <= q_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end
endmodule
`default_nettype wire
